[hw/rtl/annexb_parameter_set_extractor_defines.svh]
// Assertion macros shared by the parameter set extractor RTL
`ifndef ANNEXB_PARAMETER_SET_EXTRACTOR_DEFINES_SVH
`define ANNEXB_PARAMETER_SET_EXTRACTOR_DEFINES_SVH

// same-cycle implication
`define APSE_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication
`define APSE_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

[hw/rtl/apse_pkg.sv]
// Package: constants, codes and shared types of the parameter set extractor
`timescale 1ns / 1ps

package apse_pkg;

   localparam int MAX_SET_BYTES = 64;
   localparam int POS_W         = $clog2(MAX_SET_BYTES);
   localparam int COUNT_CAP     = MAX_SET_BYTES + 8;
   localparam int CNT_W         = $clog2(COUNT_CAP + 1);
   localparam int LEN_W         = $clog2(MAX_SET_BYTES + 1);
   localparam int IDX_W         = 6;
   localparam int SET_LEN_W     = 7;
   localparam int CMP_W         = ((LEN_W > IDX_W) ? LEN_W : IDX_W) + 1;
   localparam int RAM_DEPTH     = 4 * MAX_SET_BYTES;
   localparam int RAM_AW        = POS_W + 2;
   localparam int HDR_POS       = 4;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic REG_REQUIRE_LEADING = 1'b0;

   localparam logic [31:0] START_CODE    = 32'h0000_0001;
   localparam logic [7:0]  NAL_TYPE_MASK = 8'h1f;
   localparam logic [7:0]  NAL_SPS       = 8'd7;
   localparam logic [7:0]  NAL_PPS       = 8'd8;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_SPS  = 2'd1;
   localparam logic [1:0] KIND_PPS  = 2'd2;

   localparam logic REQ_STREAM = 1'b0;
   localparam logic REQ_READ   = 1'b1;

   localparam logic RESULT_REPORT = 1'b0;
   localparam logic RESULT_READ   = 1'b1;

   localparam logic [1:0] SRC_ZERO = 2'd0;
   localparam logic [1:0] SRC_ONE  = 2'd1;
   localparam logic [1:0] SRC_RAM  = 2'd2;

   typedef struct packed {
      logic              en;
      logic [RAM_AW-1:0] addr;
      logic [7:0]        data;
   } wr_type;

   typedef struct packed {
      logic accepted;
      logic sps_updated;
      logic pps_updated;
   } rpt_type;

   typedef struct packed {
      logic [LEN_W-1:0] sps_len;
      logic [LEN_W-1:0] pps_len;
      logic             sps_bank;
      logic             pps_bank;
   } store_type;

   typedef struct packed {
      logic                 result_kind;
      logic [7:0]           read_byte;
      logic [SET_LEN_W-1:0] set_length;
      logic                 frame_accepted;
      logic                 sps_updated;
      logic                 pps_updated;
   } res_type;

endpackage

[hw/rtl/apse_ram.sv]
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps

module apse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/apse_scan.sv]
// Start code scanner, unit capture and frame-end commit of stored parameter sets
`timescale 1ns / 1ps

module apse_scan (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_valid,
   input  logic [7:0]          data_byte,
   input  logic                last_of_frame,
   input  logic                require_leading,
   output apse_pkg::wr_type    wr,
   output apse_pkg::rpt_type   rpt,
   output apse_pkg::store_type store
);

   logic [31:0]                    recent_ff, recent_in;
   logic [2:0]                     pos_ff, pos_in;
   logic                           ok_ff, ok_in;
   logic [1:0]                     kind_ff, kind_in;
   logic [apse_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [apse_pkg::LEN_W-1:0]     plen_sps_ff, plen_sps_in;
   logic [apse_pkg::LEN_W-1:0]     plen_pps_ff, plen_pps_in;
   logic                           povf_sps_ff, povf_sps_in;
   logic                           povf_pps_ff, povf_pps_in;
   apse_pkg::store_type            store_ff, store_in;

   always_comb begin
      logic [31:0]                window;
      logic [7:0]                 nal;
      logic [apse_pkg::CNT_W-1:0] cnt_next;
      logic [1:0]                 wr_kind;
      logic [apse_pkg::CNT_W-1:0] wr_pos;
      logic                       wr_bank;
      logic                       close_en;
      logic [1:0]                 close_kind;
      logic [apse_pkg::CNT_W-1:0] close_len;
      logic                       over;
      logic [apse_pkg::LEN_W-1:0] kept;
      logic                       accepted;

      recent_in   = recent_ff;
      pos_in      = pos_ff;
      ok_in       = ok_ff;
      kind_in     = kind_ff;
      cnt_in      = cnt_ff;
      plen_sps_in = plen_sps_ff;
      plen_pps_in = plen_pps_ff;
      povf_sps_in = povf_sps_ff;
      povf_pps_in = povf_pps_ff;
      store_in    = store_ff;
      window      = {recent_ff[23:0], data_byte};
      nal         = data_byte & apse_pkg::NAL_TYPE_MASK;
      cnt_next    = cnt_ff;
      wr_kind     = apse_pkg::KIND_NONE;
      wr_pos      = '0;
      wr_bank     = 1'b0;
      close_en    = 1'b0;
      close_kind  = apse_pkg::KIND_NONE;
      close_len   = '0;
      over        = 1'b0;
      kept        = '0;
      accepted    = 1'b0;
      wr          = '0;
      rpt         = '0;

      if (byte_valid) begin
         recent_in = window;
         if (pos_ff == 3'd3 && window == apse_pkg::START_CODE) begin
            ok_in = 1'b1;
         end
         if (pos_ff < 3'd4) begin
            pos_in = pos_ff + 3'd1;
         end

         if (recent_ff == apse_pkg::START_CODE &&
             (nal == apse_pkg::NAL_SPS || nal == apse_pkg::NAL_PPS)) begin
            kind_in = (nal == apse_pkg::NAL_SPS) ? apse_pkg::KIND_SPS : apse_pkg::KIND_PPS;
            wr_kind = kind_in;
            wr_pos  = apse_pkg::CNT_W'(apse_pkg::HDR_POS);
            cnt_in  = apse_pkg::CNT_W'(apse_pkg::HDR_POS + 1);
         end else if (kind_ff != apse_pkg::KIND_NONE) begin
            wr_kind = kind_ff;
            wr_pos  = cnt_ff;
            if (cnt_ff < apse_pkg::CNT_W'(apse_pkg::COUNT_CAP)) begin
               cnt_next = cnt_ff + apse_pkg::CNT_W'(1);
            end
            cnt_in = cnt_next;
            if (window == apse_pkg::START_CODE && cnt_next >= apse_pkg::CNT_W'(4)) begin
               close_en   = 1'b1;
               close_kind = kind_ff;
               close_len  = cnt_next - apse_pkg::CNT_W'(4);
            end
         end

         if (!close_en && last_of_frame && kind_in != apse_pkg::KIND_NONE) begin
            close_en   = 1'b1;
            close_kind = kind_in;
            close_len  = cnt_in;
         end

         wr_bank = (wr_kind == apse_pkg::KIND_PPS) ? ~store_ff.pps_bank : ~store_ff.sps_bank;
         wr.en   = (wr_kind != apse_pkg::KIND_NONE) &&
                   (wr_pos < apse_pkg::CNT_W'(apse_pkg::MAX_SET_BYTES));
         wr.addr = {wr_kind == apse_pkg::KIND_PPS, wr_bank, apse_pkg::POS_W'(wr_pos)};
         wr.data = data_byte;

         if (close_en) begin
            over = close_len > apse_pkg::CNT_W'(apse_pkg::MAX_SET_BYTES);
            kept = over ? '0 : apse_pkg::LEN_W'(close_len);
            if (close_kind == apse_pkg::KIND_SPS) begin
               plen_sps_in = kept;
               povf_sps_in = over;
            end else if (close_kind == apse_pkg::KIND_PPS) begin
               plen_pps_in = kept;
               povf_pps_in = over;
            end
            kind_in = apse_pkg::KIND_NONE;
            cnt_in  = '0;
         end

         if (last_of_frame) begin
            accepted        = !require_leading || ok_in;
            rpt.accepted    = accepted;
            rpt.sps_updated = accepted && !povf_sps_in && plen_sps_in != '0;
            rpt.pps_updated = accepted && !povf_pps_in && plen_pps_in != '0;
            if (rpt.sps_updated) begin
               store_in.sps_len  = plen_sps_in;
               store_in.sps_bank = ~store_ff.sps_bank;
            end
            if (rpt.pps_updated) begin
               store_in.pps_len  = plen_pps_in;
               store_in.pps_bank = ~store_ff.pps_bank;
            end
            recent_in   = '1;
            pos_in      = '0;
            ok_in       = 1'b0;
            kind_in     = apse_pkg::KIND_NONE;
            cnt_in      = '0;
            plen_sps_in = '0;
            plen_pps_in = '0;
            povf_sps_in = 1'b0;
            povf_pps_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recent_ff   <= '1;
         pos_ff      <= '0;
         ok_ff       <= 1'b0;
         kind_ff     <= apse_pkg::KIND_NONE;
         cnt_ff      <= '0;
         plen_sps_ff <= '0;
         plen_pps_ff <= '0;
         povf_sps_ff <= 1'b0;
         povf_pps_ff <= 1'b0;
         store_ff    <= '0;
      end else begin
         recent_ff   <= recent_in;
         pos_ff      <= pos_in;
         ok_ff       <= ok_in;
         kind_ff     <= kind_in;
         cnt_ff      <= cnt_in;
         plen_sps_ff <= plen_sps_in;
         plen_pps_ff <= plen_pps_in;
         povf_sps_ff <= povf_sps_in;
         povf_pps_ff <= povf_pps_in;
         store_ff    <= store_in;
      end
   end

   assign store = store_ff;

endmodule

[hw/rtl/annexb_parameter_set_extractor.sv]
// Top level: request handling, parameter set memory, read path and result stages
//
// Usage:
//   req channel (valid/ready) carries one transaction per byte of an Annex-B
//   frame (req_type 0, req_last_of_frame on the final byte) or a read of a
//   stored parameter set byte (req_type 1, req_set_select, req_read_index).
//   rsp channel (valid/ready) returns an end-of-frame report for every last
//   byte and a read reply for every read; other stream bytes give nothing.
//   Stored sets live in one 256 x 8 RAM, banked by set type and by committed
//   versus pending copy; a frame-end commit flips the bank, so no copy runs.
//   A result is held in the stage register, which the registered RAM read
//   feeds, and then in the output register that drives rsp_valid.
//   Throughput: one transaction per cycle while req_ready is high, limited
//   by the single RAM write port and the single read port.
//   The APB port holds require_leading_start at address 0 (reset 1).
//   Reset clears scan state and stored lengths; no memory clearing is needed.
//   When rsp_ready is low, one result waits in the output register and one
//   more in the stage behind it; req_ready drops only when both are full.
`timescale 1ns / 1ps
`include "annexb_parameter_set_extractor_defines.svh"

module annexb_parameter_set_extractor (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_type,
   input  logic [7:0]                   req_data_byte,
   input  logic                         req_last_of_frame,
   input  logic                         req_set_select,
   input  logic [apse_pkg::IDX_W-1:0]   req_read_index,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_result_kind,
   output logic [7:0]                   rsp_read_byte,
   output logic [apse_pkg::SET_LEN_W-1:0] rsp_set_length,
   output logic                         rsp_frame_accepted,
   output logic                         rsp_sps_updated,
   output logic                         rsp_pps_updated,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [apse_pkg::CSR_AW-1:0]  paddr,
   input  logic [apse_pkg::CSR_DW-1:0]  pwdata,
   output logic [apse_pkg::CSR_DW-1:0]  prdata,
   output logic                         pready
);

   logic                   require_ff, require_in;
   logic                   acc;
   logic                   stream_acc;
   logic                   read_acc;
   logic                   out_free;
   logic                   s1_adv;
   logic                   s1_valid_ff, s1_valid_in;
   apse_pkg::res_type      s1_ff, s1_in;
   logic [1:0]             s1_src_ff, s1_src_in;
   logic                   out_valid_ff, out_valid_in;
   apse_pkg::res_type      out_ff, out_in;
   apse_pkg::wr_type       wr;
   apse_pkg::rpt_type      rpt;
   apse_pkg::store_type    store;
   logic [apse_pkg::RAM_AW-1:0] raddr;
   logic [7:0]             rdata;
   logic [apse_pkg::LEN_W-1:0]  sel_len;
   logic [apse_pkg::CMP_W-1:0]  idx_cmp;
   logic                   csr_hit;

   assign csr_hit    = paddr[apse_pkg::CSR_AW-1:2] == apse_pkg::REG_REQUIRE_LEADING;
   assign pready     = 1'b1;
   assign require_in = (psel && penable && pwrite && pready && csr_hit) ? pwdata[0] : require_ff;
   assign prdata     = csr_hit ? apse_pkg::CSR_DW'(require_ff) : '0;

   assign out_free   = !out_valid_ff || rsp_ready;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_ready  = !s1_valid_ff || out_free;
   assign acc        = req_valid && req_ready;
   assign stream_acc = acc && req_type == apse_pkg::REQ_STREAM;
   assign read_acc   = acc && req_type == apse_pkg::REQ_READ;

   apse_scan u_scan (
      .clock           (clock),
      .reset           (reset),
      .byte_valid      (stream_acc),
      .data_byte       (req_data_byte),
      .last_of_frame   (req_last_of_frame),
      .require_leading (require_ff),
      .wr              (wr),
      .rpt             (rpt),
      .store           (store)
   );

   assign sel_len = req_set_select ? store.pps_len : store.sps_len;
   assign idx_cmp = apse_pkg::CMP_W'(req_read_index);
   assign raddr   = {req_set_select,
                     req_set_select ? store.pps_bank : store.sps_bank,
                     apse_pkg::POS_W'(req_read_index)};

   apse_ram #(
      .WIDTH (8),
      .DEPTH (apse_pkg::RAM_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (wr.en),
      .waddr (wr.addr),
      .wdata (wr.data),
      .re    (read_acc),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_comb begin
      s1_in     = s1_ff;
      s1_src_in = s1_src_ff;
      if (read_acc) begin
         s1_in.result_kind    = apse_pkg::RESULT_READ;
         s1_in.read_byte      = '0;
         s1_in.set_length     = apse_pkg::SET_LEN_W'(sel_len);
         s1_in.frame_accepted = 1'b0;
         s1_in.sps_updated    = 1'b0;
         s1_in.pps_updated    = 1'b0;
         if (idx_cmp < apse_pkg::CMP_W'(sel_len) &&
             idx_cmp < apse_pkg::CMP_W'(apse_pkg::MAX_SET_BYTES)) begin
            if (idx_cmp < apse_pkg::CMP_W'(apse_pkg::HDR_POS)) begin
               s1_src_in = (idx_cmp == apse_pkg::CMP_W'(apse_pkg::HDR_POS - 1)) ?
                           apse_pkg::SRC_ONE : apse_pkg::SRC_ZERO;
            end else begin
               s1_src_in = apse_pkg::SRC_RAM;
            end
         end else begin
            s1_src_in = apse_pkg::SRC_ZERO;
         end
      end else if (stream_acc) begin
         s1_in.result_kind    = apse_pkg::RESULT_REPORT;
         s1_in.read_byte      = '0;
         s1_in.set_length     = '0;
         s1_in.frame_accepted = rpt.accepted;
         s1_in.sps_updated    = rpt.sps_updated;
         s1_in.pps_updated    = rpt.pps_updated;
         s1_src_in            = apse_pkg::SRC_ZERO;
      end
   end

   assign s1_valid_in = acc ? (req_type == apse_pkg::REQ_READ || req_last_of_frame)
                            : (s1_valid_ff && !s1_adv);

   always_comb begin
      out_in = out_ff;
      if (s1_adv) begin
         out_in = s1_ff;
         case (s1_src_ff)
            apse_pkg::SRC_RAM: out_in.read_byte = rdata;
            apse_pkg::SRC_ONE: out_in.read_byte = 8'd1;
            default:           out_in.read_byte = 8'd0;
         endcase
      end
   end

   assign out_valid_in = s1_adv || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         require_ff   <= 1'b1;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         require_ff   <= require_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff     <= s1_in;
      s1_src_ff <= s1_src_in;
      out_ff    <= out_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_result_kind    = out_ff.result_kind;
   assign rsp_read_byte      = out_ff.read_byte;
   assign rsp_set_length     = out_ff.set_length;
   assign rsp_frame_accepted = out_ff.frame_accepted;
   assign rsp_sps_updated    = out_ff.sps_updated;
   assign rsp_pps_updated    = out_ff.pps_updated;

   `APSE_ASSERT_NEXT(a_read_reply, clock, reset, read_acc, s1_valid_ff && s1_ff.result_kind == apse_pkg::RESULT_READ, "read transaction did not produce a reply")
   `APSE_ASSERT_NEXT(a_end_report, clock, reset, stream_acc && req_last_of_frame, s1_valid_ff && s1_ff.result_kind == apse_pkg::RESULT_REPORT, "frame end did not produce a report")
   `APSE_ASSERT_NEXT(a_no_result, clock, reset, stream_acc && !req_last_of_frame, !s1_valid_ff, "mid-frame byte produced a result")
   `APSE_ASSERT_NOW(a_full_stall, clock, reset, s1_valid_ff && out_valid_ff && !rsp_ready, !req_ready, "transaction accepted with both result stages full")

endmodule

[tb/sv/tb.sv]
// Testbench for the Annex-B parameter set extractor: directed table, random frames, scoreboard
`timescale 1ns / 1ps

module tb;
   import apse_pkg::*;

   localparam int PHASE_ITEMS  = 470;
   localparam int DRAIN_CYCLES = 6;
   localparam int LONG_HOLD    = 300;
   localparam int STALL_LIMIT  = 2000;

   localparam logic [CSR_AW-1:0] LEAD_ADDR = CSR_AW'(4 * REG_REQUIRE_LEADING);

   typedef struct packed {
      logic             kind;
      logic [7:0]       data;
      logic             last;
      logic             sel;
      logic [IDX_W-1:0] idx;
   } stim_t;

   typedef struct packed {
      stim_t   s;
      logic    typed;
      res_type want;
   } req_item_t;

   localparam res_type NO_RES     = '0;
   localparam res_type RD_EMPTY   = '{RESULT_READ, 8'h00, 7'd0, 1'b0, 1'b0, 1'b0};
   localparam res_type RD_SPS_HDR = '{RESULT_READ, 8'h07, 7'd5, 1'b0, 1'b0, 1'b0};
   localparam res_type REP_REJECT = '{RESULT_REPORT, 8'h00, 7'd0, 1'b0, 1'b0, 1'b0};
   localparam res_type REP_SPS    = '{RESULT_REPORT, 8'h00, 7'd0, 1'b1, 1'b1, 1'b0};

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_type;
   logic [7:0]           req_data_byte;
   logic                 req_last_of_frame;
   logic                 req_set_select;
   logic [IDX_W-1:0]     req_read_index;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_result_kind;
   logic [7:0]           rsp_read_byte;
   logic [SET_LEN_W-1:0] rsp_set_length;
   logic                 rsp_frame_accepted;
   logic                 rsp_sps_updated;
   logic                 rsp_pps_updated;
   logic                 psel;
   logic                 penable;
   logic                 pwrite;
   logic [CSR_AW-1:0]    paddr;
   logic [CSR_DW-1:0]    pwdata;
   logic [CSR_DW-1:0]    prdata;
   logic                 pready;

   annexb_parameter_set_extractor u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_data_byte      (req_data_byte),
      .req_last_of_frame  (req_last_of_frame),
      .req_set_select     (req_set_select),
      .req_read_index     (req_read_index),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_read_byte      (rsp_read_byte),
      .rsp_set_length     (rsp_set_length),
      .rsp_frame_accepted (rsp_frame_accepted),
      .rsp_sps_updated    (rsp_sps_updated),
      .rsp_pps_updated    (rsp_pps_updated),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   // scanner and set store mirror; index 0 holds the sequence set, 1 the picture set
   logic                 lead_required = 1'b1;
   logic [31:0]          scan_window   = '1;
   int unsigned          scan_pos      = 0;
   logic                 lead_ok       = 1'b0;
   logic [1:0]           cap_kind      = KIND_NONE;
   int unsigned          cap_count     = 0;
   logic [7:0]           stage_mem [2][MAX_SET_BYTES];
   int unsigned          stage_len [2] = '{0, 0};
   bit                   stage_over [2] = '{0, 0};
   logic [7:0]           held_mem [2][MAX_SET_BYTES];
   logic [SET_LEN_W-1:0] held_len [2] = '{'0, '0};

   req_item_t req_queue [$];
   res_type   owed_results [$];

   int unsigned err_count   = 0;
   int unsigned phase_items = 0;
   int unsigned quiet_cycles = 0;
   int          long_hold   = 0;
   logic        calm        = 1'b0;
   int unsigned n_reads     = 0;
   int unsigned n_reports   = 0;
   int unsigned n_rejected  = 0;
   int unsigned n_sps       = 0;
   int unsigned n_pps       = 0;
   int unsigned n_oversize  = 0;

   req_item_t dir_rows [27] = '{
      '{'{REQ_READ,   8'h00, 1'b0, 1'b0, 6'd0 }, 1'b1, RD_EMPTY},
      '{'{REQ_STREAM, 8'h00, 1'b0, 1'b1, 6'd63}, 1'b0, NO_RES},
      '{'{REQ_STREAM, 8'h00, 1'b1, 1'b0, 6'd0 }, 1'b1, REP_REJECT},
      '{'{REQ_STREAM, 8'h00, 1'b0, 1'b0, 6'd0 }, 1'b0, NO_RES},
      '{'{REQ_STREAM, 8'h00, 1'b0, 1'b1, 6'd21}, 1'b0, NO_RES},
      '{'{REQ_STREAM, 8'h00, 1'b0, 1'b0, 6'd42}, 1'b0, NO_RES},
      '{'{REQ_STREAM, 8'h01, 1'b0, 1'b1, 6'd63}, 1'b0, NO_RES},
      '{'{REQ_STREAM, 8'h07, 1'b1, 1'b0, 6'd0 }, 1'b1, REP_SPS},
      '{'{REQ_STREAM, 8'h00, 1'b0, 1'b0, 6'd0 }, 1'b0, NO_RES},
      '{'{REQ_STREAM, 8'h00, 1'b0, 1'b0, 6'd0 }, 1'b0, NO_RES},
      '{'{REQ_STREAM, 8'h00, 1'b0, 1'b0, 6'd0 }, 1'b0, NO_RES},
      '{'{REQ_STREAM, 8'h01, 1'b0, 1'b0, 6'd0 }, 1'b0, NO_RES},
      '{'{REQ_STREAM, 8'h68, 1'b0, 1'b1, 6'd5 }, 1'b0, NO_RES},
      '{'{REQ_READ,   8'hff, 1'b1, 1'b0, 6'd4 }, 1'b1, RD_SPS_HDR},
      '{'{REQ_STREAM, 8'haa, 1'b0, 1'b0, 6'd0 }, 1'b0, NO_RES},
      '{'{REQ_STREAM, 8'h00, 1'b0, 1'b0, 6'd0 }, 1'b0, NO_RES},
      '{'{REQ_STREAM, 8'h00, 1'b0, 1'b0, 6'd0 }, 1'b0, NO_RES},
      '{'{REQ_STREAM, 8'h00, 1'b0, 1'b0, 6'd0 }, 1'b0, NO_RES},
      '{'{REQ_STREAM, 8'h01, 1'b0, 1'b0, 6'd0 }, 1'b0, NO_RES},
      '{'{REQ_STREAM, 8'he7, 1'b0, 1'b0, 6'd0 }, 1'b0, NO_RES},
      '{'{REQ_STREAM, 8'hff, 1'b1, 1'b1, 6'd63}, 1'b0, NO_RES},
      '{'{REQ_STREAM, 8'hff, 1'b0, 1'b0, 6'd0 }, 1'b0, NO_RES},
      '{'{REQ_STREAM, 8'h00, 1'b0, 1'b0, 6'd0 }, 1'b0, NO_RES},
      '{'{REQ_STREAM, 8'h00, 1'b0, 1'b0, 6'd0 }, 1'b0, NO_RES},
      '{'{REQ_STREAM, 8'h00, 1'b0, 1'b0, 6'd0 }, 1'b0, NO_RES},
      '{'{REQ_STREAM, 8'h01, 1'b0, 1'b0, 6'd0 }, 1'b0, NO_RES},
      '{'{REQ_STREAM, 8'h08, 1'b1, 1'b0, 6'd0 }, 1'b1, REP_REJECT}
   };

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $time);
      err_count++;
   endtask

   function automatic void stage_byte(input int unsigned pos, input logic [7:0] v);
      if (pos < MAX_SET_BYTES && cap_kind != KIND_NONE)
         stage_mem[cap_kind == KIND_PPS][pos] = v;
   endfunction

   function automatic void close_unit(input int unsigned len);
      if (cap_kind != KIND_NONE) begin
         stage_over[cap_kind == KIND_PPS] = (len > MAX_SET_BYTES);
         stage_len[cap_kind == KIND_PPS]  = (len > MAX_SET_BYTES) ? 0 : len;
         if (len > MAX_SET_BYTES)
            n_oversize++;
      end
      cap_kind  = KIND_NONE;
      cap_count = 0;
   endfunction

   function automatic bit extract_result(input stim_t s, output res_type r);
      logic [31:0] prior;
      logic [7:0]  nal;
      bit          opened;
      bit          ok;
      bit [1:0]    upd;
      r = '0;
      if (s.kind == REQ_READ) begin
         r.result_kind = RESULT_READ;
         r.set_length  = held_len[s.sel];
         r.read_byte   = (s.idx < held_len[s.sel]) ? held_mem[s.sel][s.idx] : 8'h00;
         n_reads++;
         return 1'b1;
      end
      prior       = scan_window;
      scan_window = {prior[23:0], s.data};
      nal         = s.data & NAL_TYPE_MASK;
      if (scan_pos == 3 && scan_window == START_CODE)
         lead_ok = 1'b1;
      if (scan_pos < 4)
         scan_pos++;
      opened = 1'b0;
      if (prior == START_CODE && (nal == NAL_SPS || nal == NAL_PPS)) begin
         cap_kind = (nal == NAL_SPS) ? KIND_SPS : KIND_PPS;
         stage_byte(0, 8'h00);
         stage_byte(1, 8'h00);
         stage_byte(2, 8'h00);
         stage_byte(3, 8'h01);
         stage_byte(4, s.data);
         cap_count = 5;
         opened    = 1'b1;
      end
      if (!opened && cap_kind != KIND_NONE) begin
         stage_byte(cap_count, s.data);
         if (cap_count < COUNT_CAP)
            cap_count++;
         if (scan_window == START_CODE && cap_count >= 4)
            close_unit(cap_count - 4);
      end
      if (!s.last)
         return 1'b0;
      if (cap_kind != KIND_NONE)
         close_unit(cap_count);
      ok  = !lead_required || lead_ok;
      upd = '0;
      for (int k = 0; k < 2; k++) begin
         if (ok && !stage_over[k] && stage_len[k] >= 1 && stage_len[k] <= MAX_SET_BYTES) begin
            for (int j = 0; j < stage_len[k]; j++)
               held_mem[k][j] = stage_mem[k][j];
            held_len[k] = SET_LEN_W'(stage_len[k]);
            upd[k]      = 1'b1;
         end
      end
      r.result_kind    = RESULT_REPORT;
      r.frame_accepted = ok;
      r.sps_updated    = upd[0];
      r.pps_updated    = upd[1];
      n_reports++;
      n_rejected += !ok;
      n_sps      += upd[0];
      n_pps      += upd[1];
      scan_window = '1;
      scan_pos    = 0;
      lead_ok     = 1'b0;
      cap_kind    = KIND_NONE;
      cap_count   = 0;
      stage_len   = '{0, 0};
      stage_over  = '{0, 0};
      return 1'b1;
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 3))
         0: return 8'h00;
         1: return 8'h01;
         2: return {3'($urandom), ($urandom_range(0, 1) ? NAL_SPS[4:0] : NAL_PPS[4:0])};
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void queue_read();
      req_item_t it;
      it        = '0;
      it.s.kind = REQ_READ;
      it.s.data = 8'($urandom);
      it.s.last = 1'($urandom);
      it.s.sel  = 1'($urandom);
      it.s.idx  = $urandom_range(0, 1) ? IDX_W'($urandom_range(0, 12))
                                       : IDX_W'($urandom_range(0, 63));
      req_queue.push_back(it);
      phase_items++;
   endfunction

   task automatic queue_frame();
      logic [7:0] fb [$];
      req_item_t  it;
      int         units;
      int         plen;
      logic [7:0] nal;
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 10)) fb.push_back(noise_byte());
      end else begin
         if ($urandom_range(0, 7) == 0)
            fb.push_back(noise_byte());
         units = $urandom_range(1, 3);
         for (int u = 0; u < units; u++) begin
            if (u == 0 || $urandom_range(0, 7) != 0)
               fb.push_back(8'h00);
            fb.push_back(8'h00);
            fb.push_back(8'h00);
            fb.push_back(8'h01);
            case ($urandom_range(0, 4))
               0, 1: nal = NAL_SPS;
               2, 3: nal = NAL_PPS;
               default: nal = 8'($urandom_range(0, 31));
            endcase
            fb.push_back({3'($urandom), nal[4:0]});
            plen = ($urandom_range(0, 7) == 0) ? $urandom_range(52, 72) : $urandom_range(0, 10);
            repeat (plen) fb.push_back(8'($urandom));
         end
      end
      foreach (fb[i]) begin
         if ($urandom_range(0, 5) == 0)
            queue_read();
         it   = '0;
         it.s = '{REQ_STREAM, fb[i], (i == fb.size() - 1), 1'($urandom), IDX_W'($urandom)};
         req_queue.push_back(it);
         phase_items++;
      end
   endtask

   task automatic drain();
      while (req_queue.size() != 0 || owed_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_lead_check(input logic want_lead);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= LEAD_ADDR;
      pwdata  <= CSR_DW'(want_lead);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[0] !== want_lead)
         report_mismatch("require_leading_start readback", prdata[0], want_lead);
      psel          <= 1'b0;
      penable       <= 1'b0;
      lead_required  = want_lead;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // request driver: predict at acceptance
   initial begin
      req_item_t it;
      res_type   r;
      req_valid         <= 1'b0;
      req_type          <= REQ_STREAM;
      req_data_byte     <= 8'h00;
      req_last_of_frame <= 1'b0;
      req_set_select    <= 1'b0;
      req_read_index    <= '0;
      @(posedge clock);
      forever begin
         if (req_queue.size() == 0) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end else begin
            if (!calm && $urandom_range(0, 5) == 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 14)) @(posedge clock);
            end
            it                 = req_queue[0];
            req_valid         <= 1'b1;
            req_type          <= it.s.kind;
            req_data_byte     <= it.s.data;
            req_last_of_frame <= it.s.last;
            req_set_select    <= it.s.sel;
            req_read_index    <= it.s.idx;
            do @(posedge clock); while (!req_ready);
            void'(req_queue.pop_front());
            if (extract_result(it.s, r))
               owed_results.push_back(it.typed ? it.want : r);
         end
      end
   end

   // result receiver: random backpressure, one long hold on request
   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold == 1) begin
            long_hold  = 2;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold  = 0;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(0, 5) == 0 ? $urandom_range(30, 80) : $urandom_range(1, 12))
               @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      res_type got;
      res_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_result_kind, rsp_read_byte, rsp_set_length, rsp_frame_accepted,
                 rsp_sps_updated, rsp_pps_updated};
         if (owed_results.size() == 0) begin
            report_mismatch("transaction with nothing due", got, 0);
         end else begin
            want = owed_results.pop_front();
            if (got.result_kind !== want.result_kind)
               report_mismatch("result_kind", got.result_kind, want.result_kind);
            if (got.read_byte !== want.read_byte)
               report_mismatch("read_byte", got.read_byte, want.read_byte);
            if (got.set_length !== want.set_length)
               report_mismatch("set_length", got.set_length, want.set_length);
            if (got.frame_accepted !== want.frame_accepted)
               report_mismatch("frame_accepted", got.frame_accepted, want.frame_accepted);
            if (got.sps_updated !== want.sps_updated)
               report_mismatch("sps_updated", got.sps_updated, want.sps_updated);
            if (got.pps_updated !== want.pps_updated)
               report_mismatch("pps_updated", got.pps_updated, want.pps_updated);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("stalled for %0d cycles", quiet_cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      bit paused;
      bit held;
      reset   <= 1'b1;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= '0;
      pwdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_rows[i])
         req_queue.push_back(dir_rows[i]);
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         set_lead_check(ph % 2 == 0);
         calm        = (ph == 3);
         phase_items = 0;
         paused      = 1'b0;
         held        = 1'b0;
         while (phase_items < PHASE_ITEMS) begin
            if (ph == 0 && !paused && phase_items > PHASE_ITEMS / 2) begin
               drain();
               paused = 1'b1;
            end
            if (ph == 1 && !held && phase_items > PHASE_ITEMS / 3) begin
               long_hold = 1;
               while (long_hold != 2)
                  @(posedge clock);
               repeat (30) queue_read();
               held = 1'b1;
            end
            queue_frame();
            while (req_queue.size() > 12)
               @(posedge clock);
         end
         drain();
      end
      $display("ran %0d frame reports (%0d rejected) and %0d reads over four phases,",
               n_reports, n_rejected, n_reads);
      $display("leading check on and off; stored %0d sequence and %0d picture sets, %0d too long",
               n_sps, n_pps, n_oversize);
      if (err_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
